@@ rtl/core/lbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lbs_pkg;

  localparam int COORD_W     = 32;
  localparam int SUM_W       = 48;
  localparam int WEIGHT_W    = 17;
  localparam int WEIGHT_FRAC = 16;
  localparam int WPROD_W     = SUM_W + WEIGHT_W;
  localparam int CONTRIB_W   = WPROD_W - WEIGHT_FRAC;
  localparam int SUM_ADD_W   = CONTRIB_W + 1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  localparam logic signed [SUM_W-1:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] S48_MIN = 48'sh8000_0000_0000;
  localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh8000_0000;

  localparam logic ACT_WRITE     = 1'b0;
  localparam logic ACT_INFLUENCE = 1'b1;

  localparam logic [1:0] TRANS_COL = 2'd3;
  localparam logic [1:0] LAST_ROW  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic       load;
    logic       wr;
    logic       rd;
    logic [1:0] col;
    logic [1:0] row;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic bone_ok;
    logic last;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [SUM_W-1:0] sat_to_s48(
    input logic signed [SUM_ADD_W-1:0] v
  );
    logic signed [SUM_W-1:0] r;
    if (v > SUM_ADD_W'(S48_MAX)) begin
      r = S48_MAX;
    end else if (v < SUM_ADD_W'(S48_MIN)) begin
      r = S48_MIN;
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_to_s32(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [COORD_W-1:0] r;
    if (v > SUM_W'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < SUM_W'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/lbs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/lbs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lbs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               action_i,
  input  wire lbs_pkg::dp_status_t status_i,
  output lbs_pkg::dp_cmd_t        cmd_o
);

  import lbs_pkg::*;

  ctl_state_e state_q, state_d;
  logic [1:0] col_q, col_d;
  logic [1:0] row_q, row_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    case (state_q)
      ST_IDLE: begin
        col_d = '0;
        row_d = '0;
        if (in_valid_i && (action_i == ACT_INFLUENCE)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (col_q == TRANS_COL) begin
          col_d = '0;
          row_d = row_q + 2'd1;
        end else begin
          col_d = col_q + 2'd1;
        end
        if (!status_i.bone_ok || ((row_q == LAST_ROW) && (col_q == TRANS_COL))) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.busy) begin
          state_d = status_i.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_WRITE) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd_o.rd  = status_i.bone_ok;
        cmd_o.col = col_q;
        cmd_o.row = row_q;
      end
      ST_DRAIN: begin
        cmd_o.rd = 1'b0;
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/lbs_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lbs_datapath #(
  parameter int BONE_COUNT = 64,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lbs_pkg::dp_cmd_t            cmd_i,
  output lbs_pkg::dp_status_t              status_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_direction_mode_i,
  input  wire logic [5:0]                  bone_id_i,
  input  wire logic [3:0]                  element_index_i,
  input  wire logic signed [31:0]          element_value_i,
  input  wire logic signed [31:0]          coord_x_i,
  input  wire logic signed [31:0]          coord_y_i,
  input  wire logic signed [31:0]          coord_z_i,
  input  wire logic [16:0]                 weight_i,
  input  wire logic                        last_influence_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [31:0]               out_x_o,
  output logic signed [31:0]               out_y_o,
  output logic signed [31:0]               out_z_o
);

  import lbs_pkg::*;

  localparam int DEPTH  = BONE_COUNT * 16;
  localparam int AW     = $clog2(DEPTH);
  localparam int PROD_W = 2 * COORD_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int ACC_W  = (TERM_W + 2 > SUM_W + 1) ? TERM_W + 2 : SUM_W + 1;
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(S48_MAX);
  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(S48_MIN);

  // configuration
  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_direction_mode_i;
    end
  end

  // latched influence word
  logic [5:0]               bone_q;
  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic [WEIGHT_W-1:0]      w_q;
  logic                     last_q;
  logic                     bone_ok_q;
  logic                     bone_in_ok;

  assign bone_in_ok = (32'(bone_id_i) < BONE_COUNT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bone_q    <= bone_id_i;
      cx_q      <= coord_x_i;
      cy_q      <= coord_y_i;
      cz_q      <= coord_z_i;
      w_q       <= (weight_i > WEIGHT_ONE) ? WEIGHT_ONE : weight_i;
      last_q    <= last_influence_i;
      bone_ok_q <= bone_in_ok;
    end
  end

  // bone matrix table
  logic [COORD_W-1:0] ram_rdata;

  lbs_ram #(
    .WIDTH(COORD_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr && bone_in_ok),
    .waddr_i(AW'({bone_id_i, element_index_i})),
    .wdata_i(element_value_i),
    .re_i   (cmd_i.rd),
    .raddr_i(AW'({bone_q, cmd_i.col, cmd_i.row})),
    .rdata_o(ram_rdata)
  );

  // pipeline valids
  logic p1_v_q, p2_v_q, t_v_q, c_v_q;
  logic [1:0] p1_col_q, p1_row_q, p2_col_q, p2_row_q, t_row_q, c_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      t_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
    end else begin
      p1_v_q <= cmd_i.rd;
      p2_v_q <= p1_v_q;
      t_v_q  <= p2_v_q && (p2_col_q == TRANS_COL);
      c_v_q  <= t_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_col_q <= cmd_i.col;
    p1_row_q <= cmd_i.row;
    p2_col_q <= p1_col_q;
    p2_row_q <= p1_row_q;
    t_row_q  <= p2_row_q;
    c_row_q  <= t_row_q;
  end

  // element times coordinate
  logic signed [COORD_W-1:0] vsel;
  logic signed [PROD_W-1:0]  mprod;
  logic signed [TERM_W-1:0]  term_d, term_q;

  always_comb begin
    case (p1_col_q)
      2'd0:    vsel = cx_q;
      2'd1:    vsel = cy_q;
      default: vsel = cz_q;
    endcase
  end

  assign mprod = $signed(ram_rdata) * vsel;

  always_comb begin
    if (p1_col_q == TRANS_COL) begin
      term_d = mode_q ? '0 : TERM_W'($signed(ram_rdata));
    end else begin
      term_d = $signed(mprod[PROD_W-1:FRAC_BITS]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_v_q) begin
      term_q <= term_d;
    end
  end

  // row sum
  logic signed [ACC_W-1:0] acc_q, acc_next;
  logic signed [SUM_W-1:0] t_q, t_sat;

  assign acc_next = ((p2_col_q == 2'd0) ? '0 : acc_q) + ACC_W'(term_q);

  always_comb begin
    if (acc_next > ACC_HI) begin
      t_sat = S48_MAX;
    end else if (acc_next < ACC_LO) begin
      t_sat = S48_MIN;
    end else begin
      t_sat = acc_next[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_v_q) begin
      acc_q <= acc_next;
      t_q   <= t_sat;
    end
  end

  // weight scaling
  logic signed [WPROD_W:0]   wprod_full;
  logic signed [WPROD_W-1:0] wprod_q;
  logic signed [CONTRIB_W-1:0] contrib;

  assign wprod_full = t_q * $signed({1'b0, w_q});

  always_ff @(posedge clk_i) begin
    if (t_v_q) begin
      wprod_q <= wprod_full[WPROD_W-1:0];
    end
  end

  assign contrib = $signed(wprod_q[WPROD_W-1:WEIGHT_FRAC]);

  // running sums
  logic signed [SUM_W-1:0]     sum_q [3];
  logic signed [SUM_ADD_W-1:0] sum_add;

  assign sum_add = SUM_ADD_W'(sum_q[c_row_q]) + SUM_ADD_W'(contrib);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      sum_q[2] <= '0;
    end else if (cmd_i.emit) begin
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      sum_q[2] <= '0;
    end else if (c_v_q) begin
      sum_q[c_row_q] <= sat_to_s48(sum_add);
    end
  end

  // output word
  logic out_valid_q;
  logic signed [COORD_W-1:0] out_x_q, out_y_q, out_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_x_q <= sat_to_s32(sum_q[0]);
      out_y_q <= sat_to_s32(sum_q[1]);
      out_z_q <= sat_to_s32(sum_q[2]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;

  assign status_o.busy     = p1_v_q || p2_v_q || t_v_q || c_v_q;
  assign status_o.bone_ok  = bone_ok_q;
  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

@@ rtl/core/linear_blend_skinning_unit.sv @@
// channel   direction  handshake               word
// in        input      in_valid_i / in_stall_o  action, bone, element, coords, weight, last
// out       output     out_valid_o / out_stall_i out_x, out_y, out_z
// cfg       input      cfg_valid_i / cfg_ready_o direction_mode
//
// Matrix element write: taken in idle and written straight to the table. Influence:
// 12 table reads through one read port and one shared 32x32 multiplier, then the
// product, row sum, weight multiply and sum update stages, plus loading the output
// word on the last. Reset clears control, sums and direction_mode; the table is
// unspecified until written. out_stall_i holds a finished word while the next
// influence is already taken in; only emitting waits for the output to free.
`timescale 1ns / 1ps
`default_nettype none

module linear_blend_skinning_unit #(
  parameter int BONE_COUNT = 64,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_direction_mode_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               action_i,
  input  wire logic [5:0]         bone_id_i,
  input  wire logic [3:0]         element_index_i,
  input  wire logic signed [31:0] element_value_i,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  input  wire logic signed [31:0] coord_z_i,
  input  wire logic [16:0]        weight_i,
  input  wire logic               last_influence_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o
);

  import lbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  lbs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .action_i  (action_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lbs_datapath #(
    .BONE_COUNT(BONE_COUNT),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_direction_mode_i(cfg_direction_mode_i),
    .bone_id_i           (bone_id_i),
    .element_index_i     (element_index_i),
    .element_value_i     (element_value_i),
    .coord_x_i           (coord_x_i),
    .coord_y_i           (coord_y_i),
    .coord_z_i           (coord_z_i),
    .weight_i            (weight_i),
    .last_influence_i    (last_influence_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_x_o             (out_x_o),
    .out_y_o             (out_y_o),
    .out_z_o             (out_z_o)
  );

endmodule

`default_nettype wire
